/* hdl/apr_pkg.sv */
package apr_pkg;

  // Table geometry
  localparam int TABLE_ENTRIES = 16;
  localparam int AGE_BITS      = 8;
  localparam int PAGE_BITS     = 20;
  localparam int CFG_W         = 5;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int OCC_W         = IDX_W + 1;

  localparam logic [AGE_BITS-1:0] AGE_TOP = {1'b1, {(AGE_BITS-1){1'b0}}};
  localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [AGE_BITS-1:0]  age_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [OCC_W-1:0]     occ_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MIN,
    ST_EVICT,
    ST_INSERT
  } apr_state_e;

  // Result of one request
  typedef struct packed {
    page_t page;
    logic  fault;
  } apr_result_t;

  // Frame limit: zero acts as one, anything above the table size as the size
  function automatic occ_t lim_clamp(logic [CFG_W-1:0] v);
    occ_t r;
    if (v == '0) begin
      r = occ_t'(1);
    end else if (32'(v) > TABLE_ENTRIES) begin
      r = occ_t'(TABLE_ENTRIES);
    end else begin
      r = occ_t'(v);
    end
    return r;
  endfunction

endpackage

/* hdl/apr_engine.sv */
module apr_engine
  import apr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  page_t       page_i,
  input  occ_t        lim_i,
  output logic        busy_o,
  output logic        done_o,
  output apr_result_t result_o
);

  apr_state_e state_q, state_d;

  page_t tag_q   [TABLE_ENTRIES];
  age_t  age_q   [TABLE_ENTRIES];
  age_t  age_d   [TABLE_ENTRIES];
  idx_t  order_q [TABLE_ENTRIES];
  idx_t  order_d [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;

  occ_t  occ_q, occ_d;
  idx_t  cnt_q, cnt_d;
  idx_t  pick_q, pick_d;
  age_t  best_q, best_d;
  page_t page_q, page_d;
  logic  hit_q, hit_d;
  logic  done_q, done_d;

  logic  tag_we;
  idx_t  tag_wa;

  // Shared read port: slot under scan, or slot at the scanned rank
  idx_t  rd_slot;
  age_t  rd_age;
  logic  match;
  logic  hit_now;
  logic  min_last;
  logic  take_min;
  idx_t  ins_slot;
  idx_t  evict_slot;

  assign rd_slot    = (state_q == ST_MIN) ? order_q[cnt_q] : cnt_q;
  assign rd_age     = age_q[rd_slot];
  assign match      = valid_q[cnt_q] && (tag_q[cnt_q] == page_q);
  assign hit_now    = hit_q | match;
  assign min_last   = (occ_t'(cnt_q) + occ_t'(1)) == occ_q;
  assign take_min   = (rd_age <= best_q);
  assign ins_slot   = order_q[occ_q[IDX_W-1:0]];
  assign evict_slot = order_q[pick_q];

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (cnt_q == idx_t'(TABLE_ENTRIES - 1)) begin
          if (hit_now) state_d = ST_IDLE;
          else if (occ_q >= lim_i) state_d = ST_MIN;
          else state_d = ST_INSERT;
        end
      end
      ST_MIN: begin
        if (min_last) state_d = ST_EVICT;
      end
      ST_EVICT: begin
        if ((occ_q - occ_t'(1)) >= lim_i) state_d = ST_MIN;
        else state_d = ST_INSERT;
      end
      ST_INSERT: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Datapath and table updates
  always_comb begin
    age_d   = age_q;
    order_d = order_q;
    valid_d = valid_q;
    occ_d   = occ_q;
    cnt_d   = cnt_q;
    pick_d  = pick_q;
    best_d  = best_q;
    page_d  = page_q;
    hit_d   = hit_q;
    done_d  = 1'b0;
    tag_we  = 1'b0;
    tag_wa  = ins_slot;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          page_d = page_i;
          hit_d  = 1'b0;
          cnt_d  = '0;
        end
      end
      ST_SCAN: begin
        // age one slot per cycle, mark a hit
        if (valid_q[cnt_q]) begin
          age_d[cnt_q] = {match, rd_age[AGE_BITS-1:1]};
        end
        hit_d = hit_now;
        cnt_d = cnt_q + idx_t'(1);
        if (cnt_q == idx_t'(TABLE_ENTRIES - 1)) begin
          cnt_d  = '0;
          best_d = AGE_MAX;
          pick_d = '0;
          done_d = hit_now;
        end
      end
      ST_MIN: begin
        // last minimum in rank order wins: oldest on a tie
        if (take_min) begin
          best_d = rd_age;
          pick_d = cnt_q;
        end
        cnt_d = cnt_q + idx_t'(1);
      end
      ST_EVICT: begin
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
          if ((idx_t'(k) >= pick_q) && ((occ_t'(k) + occ_t'(1)) < occ_q)) begin
            order_d[k] = order_q[(k + 1) % TABLE_ENTRIES];
          end else if ((occ_t'(k) + occ_t'(1)) == occ_q) begin
            order_d[k] = evict_slot;
          end
        end
        valid_d[evict_slot] = 1'b0;
        age_d[evict_slot]   = '0;
        occ_d  = occ_q - occ_t'(1);
        cnt_d  = '0;
        best_d = AGE_MAX;
        pick_d = '0;
      end
      ST_INSERT: begin
        if (occ_q < occ_t'(TABLE_ENTRIES)) begin
          for (int k = 0; k < TABLE_ENTRIES; k++) begin
            if (k == 0) begin
              order_d[k] = ins_slot;
            end else if (occ_t'(k) <= occ_q) begin
              order_d[k] = order_q[k - 1];
            end
          end
          valid_d[ins_slot] = 1'b1;
          age_d[ins_slot]   = AGE_TOP;
          tag_we = 1'b1;
          occ_d  = occ_q + occ_t'(1);
        end
        done_d = 1'b1;
      end
      default: ;
    endcase
  end

  // Control and age state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= '0;
      occ_q   <= '0;
      cnt_q   <= '0;
      pick_q  <= '0;
      best_q  <= AGE_MAX;
      hit_q   <= 1'b0;
      done_q  <= 1'b0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        age_q[i]   <= '0;
        order_q[i] <= idx_t'(i);
      end
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      occ_q   <= occ_d;
      cnt_q   <= cnt_d;
      pick_q  <= pick_d;
      best_q  <= best_d;
      hit_q   <= hit_d;
      done_q  <= done_d;
      age_q   <= age_d;
      order_q <= order_d;
    end
  end

  // Payload: page tags and the request page
  always_ff @(posedge clk_i) begin
    page_q <= page_d;
    if (tag_we) tag_q[tag_wa] <= page_q;
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign done_o         = done_q;
  assign result_o.page  = page_q;
  assign result_o.fault = ~hit_q;

  // Checks
  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= occ_t'(TABLE_ENTRIES))
    else $error("occupancy above table size");

  a_occ_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_t'($countones(valid_q)) == occ_q)
    else $error("occupancy out of step with valid bits");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == ST_IDLE))
    else $error("result strobe while sequencer busy");

  a_evict_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVICT) |-> (occ_q >= lim_i) && !hit_q)
    else $error("eviction below limit or on a hit");

  a_insert_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INSERT) |-> (occ_q < lim_i))
    else $error("insert with table at limit");

endmodule

/* hdl/aging_page_replacement.sv */
// Aging page replacement over a 16-entry table. Pulse start with a page number
// while busy is low; the request is taken at that edge and busy stays high
// until done_o pulses for one cycle with page_echo_o and page_fault_o. The
// result cannot be held off, so it must be captured in that cycle. On a hit the
// done pulse follows the scan, in which one shared age/tag unit walks all 16
// slots. A miss adds, per eviction, one pass of the minimum search over the
// resident ranks plus an evict step, then one insert step. A new request may
// start in the cycle done_o is high. The frame limit is written through
// cfg_valid_i/cfg_data_i (always ready) and should be changed only while the
// block is idle.
module aging_page_replacement
  import apr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [PAGE_BITS-1:0] page_number_i,
  output logic                 done_o,
  output logic [PAGE_BITS-1:0] page_echo_o,
  output logic                 page_fault_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  occ_t        lim_q;
  apr_result_t result;
  logic        eng_busy;

  // Frame limit register, stored already clamped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= occ_t'(TABLE_ENTRIES);
    end else if (cfg_valid_i && cfg_ready_o) begin
      lim_q <= lim_clamp(cfg_data_i);
    end
  end

  assign cfg_ready_o = 1'b1;

  apr_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start && !eng_busy),
    .page_i   (page_number_i),
    .lim_i    (lim_q),
    .busy_o   (eng_busy),
    .done_o   (done_o),
    .result_o (result)
  );

  assign busy         = eng_busy;
  assign page_echo_o  = result.page;
  assign page_fault_o = result.fault;

endmodule
